// File: sv/kcri_pkg.sv
package kcri_pkg;

    localparam int MAX_KEYS   = 8;
    localparam int ROM_KEYS   = 5;
    localparam int NCH        = 6;
    localparam int CH_W       = 8;
    localparam int TIME_W     = 17;
    localparam int OFF_W      = TIME_W + 1;
    localparam int DIFF_W     = CH_W + 1;
    localparam int PROD_W     = OFF_W + DIFF_W;
    localparam int NUM_W      = PROD_W - 1;
    localparam int DEN_W      = TIME_W;
    localparam int SUM_W      = NUM_W + 2;
    localparam int KEY_IDX_W  = 3;
    localparam int KC_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int IDX_W      = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int MAX_N      = (MAX_KEYS > ROM_KEYS) ? MAX_KEYS : ROM_KEYS;
    localparam int CNT_W      = $clog2(MAX_N);
    localparam int ROM_IDX_W  = $clog2(ROM_KEYS);
    localparam int DIV_CNT_W  = $clog2(NUM_W);

    typedef logic [NCH-1:0][CH_W-1:0] t_colors;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_COUNT   = 2'd0,
        REG_ALT_PALETTE = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic             wr_key;
        logic             cap_query;
        logic             rd_en;
        logic [CNT_W-1:0] rd_addr;
        logic             alt;
        logic             shift;
        logic             capture;
        logic             mul;
        logic             load;
        logic             div_step;
        logic             out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic out_free;
    } t_dp_sts;

    function automatic logic [TIME_W-1:0] rom_time(input logic [ROM_IDX_W-1:0] k);
        logic [TIME_W-1:0] t;
        case (k)
            3'd0:    t = 17'd0;
            3'd1:    t = 17'd16384;
            3'd2:    t = 17'd32768;
            3'd3:    t = 17'd49152;
            3'd4:    t = 17'd65536;
            default: t = '0;
        endcase
        return t;
    endfunction

    // channel order from bit 0 up: top r/g/b, bottom r/g/b
    function automatic t_colors rom_colors(input logic [ROM_IDX_W-1:0] k);
        t_colors c;
        case (k)
            3'd0:    c = {8'd252, 8'd211, 8'd162, 8'd46,  8'd5,   8'd0};
            3'd1:    c = {8'd48,  8'd33,  8'd23,  8'd21,  8'd10,  8'd6};
            3'd2:    c = {8'd244, 8'd220, 8'd170, 8'd174, 8'd142, 8'd98};
            3'd3:    c = {8'd159, 8'd101, 8'd47,  8'd93,  8'd40,  8'd0};
            3'd4:    c = {8'd252, 8'd211, 8'd162, 8'd46,  8'd5,   8'd0};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: sv/keyframe_color_ramp_interpolator_top.sv
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_cmd, i_key_index, i_key_time, i_in_*, i_day_fraction
// output    o_out_valid / i_out_ready  o_top_*, o_bottom_*
// config    i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// A key write is stored on acceptance. A query runs from acceptance to a
// loaded result in these steps: for each key scanned (2..8), a
// registered table read and a bracket compare; then multiply, operand
// load, a 26-step restoring divide run in six parallel lanes, and saturation.
// The next request is taken in the cycle after the load, so a query holds
// off the input until then; a finished result waits in the output register
// and a query behind it stalls in its last step.
// Reset (synchronous, active low) sets key_count to 2 and alt_palette to 0.
module keyframe_color_ramp_interpolator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cmd,
    input  logic [kcri_pkg::KEY_IDX_W-1:0]  i_key_index,
    input  logic [kcri_pkg::TIME_W-1:0]     i_key_time,
    input  logic [kcri_pkg::CH_W-1:0]       i_in_top_red,
    input  logic [kcri_pkg::CH_W-1:0]       i_in_top_green,
    input  logic [kcri_pkg::CH_W-1:0]       i_in_top_blue,
    input  logic [kcri_pkg::CH_W-1:0]       i_in_bottom_red,
    input  logic [kcri_pkg::CH_W-1:0]       i_in_bottom_green,
    input  logic [kcri_pkg::CH_W-1:0]       i_in_bottom_blue,
    input  logic [kcri_pkg::TIME_W-1:0]     i_day_fraction,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [kcri_pkg::CH_W-1:0]       o_top_red,
    output logic [kcri_pkg::CH_W-1:0]       o_top_green,
    output logic [kcri_pkg::CH_W-1:0]       o_top_blue,
    output logic [kcri_pkg::CH_W-1:0]       o_bottom_red,
    output logic [kcri_pkg::CH_W-1:0]       o_bottom_green,
    output logic [kcri_pkg::CH_W-1:0]       o_bottom_blue,
    input  logic                            i_cfg_we,
    input  logic [kcri_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kcri_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kcri_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_colors key_colors, out_colors;

    assign key_colors = {i_in_bottom_blue, i_in_bottom_green, i_in_bottom_red,
                         i_in_top_blue, i_in_top_green, i_in_top_red};

    kcri_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    kcri_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_key_index    (i_key_index),
        .i_key_time     (i_key_time),
        .i_key_colors   (key_colors),
        .i_day_fraction (i_day_fraction),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_colors       (out_colors),
        .o_sts          (sts)
    );

    assign o_top_red      = out_colors[0];
    assign o_top_green    = out_colors[1];
    assign o_top_blue     = out_colors[2];
    assign o_bottom_red   = out_colors[3];
    assign o_bottom_green = out_colors[4];
    assign o_bottom_blue  = out_colors[5];

`ifndef SYNTH
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an untaken result");

    a_load_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.rd_en || cmd.mul || cmd.load || cmd.div_step) |-> !o_in_ready)
        else $error("request taken while a query is in progress");

    a_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_key |-> (i_in_valid && o_in_ready && i_cmd == CMD_WRITE))
        else $error("key write without an accepted write request");
`endif

endmodule

// File: sv/kcri_ctrl.sv
module kcri_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_cmd,
    input  logic                             i_cfg_we,
    input  logic [kcri_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kcri_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  kcri_pkg::t_dp_sts                i_sts,
    output logic                             o_in_ready,
    output kcri_pkg::t_dp_cmd                o_cmd
);
    import kcri_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_LOAD  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_k, n_k;
    logic [DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic [KC_W-1:0]       r_key_count;
    logic                  r_alt;
    logic [CNT_W-1:0]      last_k;

    // index of the last key in use: the ROM's last key in alt palette mode, else key count clamped to 2..MAX_KEYS
    always_comb begin
        if (r_alt) begin
            last_k = CNT_W'(ROM_KEYS - 1);
        end else if (r_key_count < KC_W'(2)) begin
            last_k = CNT_W'(1);
        end else if (int'(r_key_count) > MAX_KEYS) begin
            last_k = CNT_W'(MAX_KEYS - 1);
        end else begin
            last_k = CNT_W'(r_key_count - KC_W'(1));
        end
    end

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_div_cnt  = r_div_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.rd_addr = r_k;
        o_cmd.alt     = r_alt;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_cmd == CMD_QUERY) begin
                        o_cmd.cap_query = 1'b1;
                        n_k     = '0;
                        n_state = S_READ;
                    end else begin
                        o_cmd.wr_key = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                if (r_k == '0) begin
                    o_cmd.shift = 1'b1;
                    n_k     = r_k + CNT_W'(1);
                    n_state = S_READ;
                end else if (i_sts.hit || r_k == last_k) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_MUL;
                end else begin
                    o_cmd.shift = 1'b1;
                    n_k     = r_k + CNT_W'(1);
                    n_state = S_READ;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_div_cnt  = DIV_CNT_W'(NUM_W - 1);
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div_cnt == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_div_cnt = r_div_cnt - DIV_CNT_W'(1);
                end
            end
            S_FIN: begin
                // wait here while the previous result is still held
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_div_cnt   <= '0;
            r_key_count <= KC_W'(2);
            r_alt       <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_div_cnt <= n_div_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KEY_COUNT:   r_key_count <= i_cfg_data[KC_W-1:0];
                    REG_ALT_PALETTE: r_alt       <= i_cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

endmodule

// File: sv/kcri_dp.sv
module kcri_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kcri_pkg::t_dp_cmd               i_cmd,
    input  logic [kcri_pkg::KEY_IDX_W-1:0]  i_key_index,
    input  logic [kcri_pkg::TIME_W-1:0]     i_key_time,
    input  kcri_pkg::t_colors               i_key_colors,
    input  logic [kcri_pkg::TIME_W-1:0]     i_day_fraction,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output kcri_pkg::t_colors               o_colors,
    output kcri_pkg::t_dp_sts               o_sts
);
    import kcri_pkg::*;

    logic [TIME_W-1:0] mem_time [MAX_KEYS];
    t_colors           mem_col  [MAX_KEYS];

    logic [TIME_W-1:0] r_mem_t, r_rom_t, cur_t;
    t_colors           r_mem_c, r_rom_c, cur_c;
    logic [TIME_W-1:0] r_d, r_prev_t, r_t0, r_t1;
    t_colors           r_prev_c, r_a, r_b;

    logic signed [PROD_W-1:0] r_prod [NCH];
    logic signed [OFF_W-1:0]  r_span;
    logic [NUM_W-1:0]         r_nq   [NCH];
    logic [DEN_W-1:0]         r_rem  [NCH];
    logic [NCH-1:0]           r_neg;
    logic [DEN_W-1:0]         r_den;
    logic                     r_zero;

    logic                     r_out_valid;
    t_colors                  r_out;

    logic                     wr_ok;
    logic signed [OFF_W-1:0]  off, span;
    logic signed [PROD_W-1:0] prod  [NCH];
    logic [DEN_W:0]           trial [NCH];
    logic [NUM_W-1:0]         n_nq  [NCH];
    logic [DEN_W-1:0]         n_rem [NCH];
    logic signed [SUM_W-1:0]  sum   [NCH];
    t_colors                  res;

    assign wr_ok = int'(i_key_index) < MAX_KEYS;
    assign cur_t = i_cmd.alt ? r_rom_t : r_mem_t;
    assign cur_c = i_cmd.alt ? r_rom_c : r_mem_c;
    assign o_sts.hit      = (r_d >= r_prev_t) && (r_d <= cur_t);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // key table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_key && wr_ok) begin
            mem_time[IDX_W'(i_key_index)] <= i_key_time;
            mem_col[IDX_W'(i_key_index)]  <= i_key_colors;
        end
        if (i_cmd.rd_en) begin
            r_mem_t <= mem_time[i_cmd.rd_addr[IDX_W-1:0]];
            r_mem_c <= mem_col[i_cmd.rd_addr[IDX_W-1:0]];
            r_rom_t <= rom_time(i_cmd.rd_addr[ROM_IDX_W-1:0]);
            r_rom_c <= rom_colors(i_cmd.rd_addr[ROM_IDX_W-1:0]);
        end
    end

    always_comb begin
        off  = $signed({1'b0, r_d}) - $signed({1'b0, r_t0});
        span = $signed({1'b0, r_t1}) - $signed({1'b0, r_t0});
        for (int c = 0; c < NCH; c++) begin
            prod[c] = PROD_W'($signed({1'b0, r_b[c]}) - $signed({1'b0, r_a[c]}))
                      * PROD_W'(off);
            // restoring divide, one quotient bit per step per lane
            trial[c] = {r_rem[c], r_nq[c][NUM_W-1]} - {1'b0, r_den};
            if (!trial[c][DEN_W]) begin
                n_rem[c] = trial[c][DEN_W-1:0];
                n_nq[c]  = {r_nq[c][NUM_W-2:0], 1'b1};
            end else begin
                n_rem[c] = {r_rem[c][DEN_W-2:0], r_nq[c][NUM_W-1]};
                n_nq[c]  = {r_nq[c][NUM_W-2:0], 1'b0};
            end
            if (r_neg[c]) begin
                sum[c] = $signed(SUM_W'(r_a[c])) - $signed(SUM_W'(r_nq[c]));
            end else begin
                sum[c] = $signed(SUM_W'(r_a[c])) + $signed(SUM_W'(r_nq[c]));
            end
            if (r_zero) begin
                res[c] = r_a[c];
            end else if (sum[c] < $signed(SUM_W'(0))) begin
                res[c] = '0;
            end else if (sum[c] > $signed(SUM_W'(255))) begin
                res[c] = 8'hFF;
            end else begin
                res[c] = sum[c][CH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_query) begin
            r_d <= i_day_fraction;
        end
        if (i_cmd.shift) begin
            r_prev_t <= cur_t;
            r_prev_c <= cur_c;
        end
        if (i_cmd.capture) begin
            r_t0 <= r_prev_t;
            r_t1 <= cur_t;
            r_a  <= r_prev_c;
            r_b  <= cur_c;
        end
        if (i_cmd.mul) begin
            r_span <= span;
            for (int c = 0; c < NCH; c++) begin
                r_prod[c] <= prod[c];
            end
        end
        if (i_cmd.load) begin
            r_den  <= r_span[OFF_W-1] ? DEN_W'(-r_span) : DEN_W'(r_span);
            r_zero <= (r_span == '0);
            for (int c = 0; c < NCH; c++) begin
                r_nq[c]  <= r_prod[c][PROD_W-1] ? NUM_W'(-r_prod[c]) : NUM_W'(r_prod[c]);
                r_rem[c] <= '0;
                r_neg[c] <= r_prod[c][PROD_W-1] ^ r_span[OFF_W-1];
            end
        end
        if (i_cmd.div_step) begin
            for (int c = 0; c < NCH; c++) begin
                r_nq[c]  <= n_nq[c];
                r_rem[c] <= n_rem[c];
            end
        end
        if (i_cmd.out_load) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_colors    = r_out;

endmodule
